// ----- rtl/flc_pkg.sv -----
// Package for the full linear convolution unit: item types, widths and register codes.
// Used by full_linear_convolution_unit; depends on nothing else.
package flc_pkg;

    // Field widths of the item formats.
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int CONV_W   = 37;
    localparam int LEN_W    = 6;

    // Default and largest sequence lengths.
    localparam int MAX_LEN_A_DEF = 32;
    localparam int MAX_LEN_B_DEF = 32;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(32);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_B = 1'b1;

    // Sequence selector carried by each input item.
    localparam logic REQ_LOAD_A = 1'b0;
    localparam logic REQ_LOAD_B = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [CONV_W-1:0] conv_value;
        logic [LEN_W-1:0]         out_index;
        logic                     last_result;
    } t_out_item;

endpackage

// ----- rtl/full_linear_convolution_unit.sv -----
// Full linear convolution unit: two sample memories and one shared multiply-accumulate.
// Depends on flc_pkg for item types, widths and register codes.
//
// An input item is taken while no run is in progress. The item that fills
// both sequences starts a run of length_a+length_b-1 results; result i walks its
// overlapping pairs through the single multiply-accumulate fed by the two memory read
// ports, and each result waits for the output register to be free before the next.
// Reset sets both lengths to 32 and clears the fill counters; memory contents are not reset.
module full_linear_convolution_unit #(
    parameter int MAX_LEN_A = flc_pkg::MAX_LEN_A_DEF,
    parameter int MAX_LEN_B = flc_pkg::MAX_LEN_B_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  flc_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output flc_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_we,
    input  logic [flc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [flc_pkg::LEN_W-1:0]          i_cfg_data
);

    localparam int AW_A = (MAX_LEN_A > 1) ? $clog2(MAX_LEN_A) : 1;
    localparam int AW_B = (MAX_LEN_B > 1) ? $clog2(MAX_LEN_B) : 1;
    localparam int LW   = flc_pkg::LEN_W;
    localparam int CW   = flc_pkg::CONV_W;
    localparam int PW   = flc_pkg::PROD_W;
    localparam int SW   = flc_pkg::SAMPLE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    // Sample memories, one read port each.
    logic signed [SW-1:0] a_mem [MAX_LEN_A];
    logic signed [SW-1:0] b_mem [MAX_LEN_B];

    t_state               r_state;
    logic [LW-1:0]        r_length_a;
    logic [LW-1:0]        r_length_b;
    logic [LW-1:0]        r_a_fill;
    logic [LW-1:0]        r_b_fill;
    logic [LW-1:0]        r_i;
    logic [LW-1:0]        r_j;
    logic signed [SW-1:0] r_a_rd;
    logic signed [SW-1:0] r_b_rd;
    logic                 r_s1_vld;
    logic                 r_s1_last;
    logic signed [PW-1:0] r_prod;
    logic                 r_s2_vld;
    logic                 r_s2_last;
    logic signed [CW-1:0] r_acc;
    logic                 r_acc_done;
    logic                 r_out_valid;
    flc_pkg::t_out_item   r_out_item;

    logic [LW-1:0]        w_la;
    logic [LW-1:0]        w_lb;
    logic [LW-1:0]        w_last_idx;
    logic                 w_accept;
    logic                 w_a_we;
    logic                 w_b_we;
    logic [LW-1:0]        n_a_fill;
    logic [LW-1:0]        n_b_fill;
    logic                 w_run_start;
    logic                 w_issue;
    logic [LW-1:0]        w_j_hi;
    logic                 w_issue_last;
    logic [LW-1:0]        w_b_idx;
    logic [LW-1:0]        w_i_nxt;
    logic [LW-1:0]        w_jlo_nxt;
    logic                 w_out_free;
    logic signed [CW-1:0] w_prod_ext;

    // Effective lengths: zero acts as one, anything above the memory depth as the depth.
    always_comb begin
        priority if (r_length_a == '0) begin
            w_la = LW'(1);
        end else if (r_length_a > LW'(MAX_LEN_A)) begin
            w_la = LW'(MAX_LEN_A);
        end else begin
            w_la = r_length_a;
        end
        priority if (r_length_b == '0) begin
            w_lb = LW'(1);
        end else if (r_length_b > LW'(MAX_LEN_B)) begin
            w_lb = LW'(MAX_LEN_B);
        end else begin
            w_lb = r_length_b;
        end
    end

    // Index of the final result; at most 62, so it fits the length width.
    assign w_last_idx = w_la + w_lb - LW'(2);

    // Loading: an item for a full sequence is dropped.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_a_we     = w_accept && (i_in_item.req_type == flc_pkg::REQ_LOAD_A)
                        && (r_a_fill < w_la) && (r_a_fill < LW'(MAX_LEN_A));
    assign w_b_we     = w_accept && (i_in_item.req_type == flc_pkg::REQ_LOAD_B)
                        && (r_b_fill < w_lb) && (r_b_fill < LW'(MAX_LEN_B));
    assign n_a_fill   = w_a_we ? r_a_fill + LW'(1) : r_a_fill;
    assign n_b_fill   = w_b_we ? r_b_fill + LW'(1) : r_b_fill;
    assign w_run_start = w_accept && (n_a_fill >= w_la) && (n_b_fill >= w_lb);

    // Pair walk for result i: j runs from max(0, i-lb+1) to min(i, la-1).
    assign w_issue      = (r_state == S_ISSUE);
    assign w_j_hi       = (r_i < w_la - LW'(1)) ? r_i : w_la - LW'(1);
    assign w_issue_last = (r_j == w_j_hi);
    assign w_b_idx      = r_i - r_j;
    assign w_i_nxt      = r_i + LW'(1);
    assign w_jlo_nxt    = (w_i_nxt >= w_lb) ? w_i_nxt - w_lb + LW'(1) : '0;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_prod_ext   = CW'(r_prod);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_a <= flc_pkg::LEN_RESET;
            r_length_b <= flc_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                flc_pkg::REG_LENGTH_A: r_length_a <= i_cfg_data;
                flc_pkg::REG_LENGTH_B: r_length_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Memory A: write on load, registered read for the multiplier.
    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            a_mem[r_a_fill[AW_A-1:0]] <= i_in_item.sample;
        end
        r_a_rd <= a_mem[r_j[AW_A-1:0]];
    end

    // Memory B: same arrangement, read at i-j.
    always_ff @(posedge i_clk) begin
        if (w_b_we) begin
            b_mem[r_b_fill[AW_B-1:0]] <= i_in_item.sample;
        end
        r_b_rd <= b_mem[w_b_idx[AW_B-1:0]];
    end

    // Read and multiply stages of the pair pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
        end
        r_s1_last <= w_issue_last;
        r_s2_last <= r_s1_last;
        r_prod    <= r_a_rd * r_b_rd;
    end

    // Sequencer: fill counters, pair walk, accumulator and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_a_fill    <= '0;
            r_b_fill    <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_acc_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_s2_vld) begin
                r_acc <= r_acc + w_prod_ext;
            end
            if (r_s2_vld && r_s2_last) begin
                r_acc_done <= 1'b1;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_a_fill <= n_a_fill;
                    r_b_fill <= n_b_fill;
                    if (w_run_start) begin
                        r_state <= S_ISSUE;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_acc   <= '0;
                    end
                end
                S_ISSUE: begin
                    if (w_issue_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_j <= r_j + LW'(1);
                    end
                end
                S_DRAIN: begin
                    // Once the sum is complete, hand it over as soon as the output register is free.
                    if (r_acc_done && w_out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out_item.conv_value  <= r_acc;
                        r_out_item.out_index   <= r_i;
                        r_out_item.last_result <= (r_i == w_last_idx);
                        r_acc_done             <= 1'b0;
                        if (r_i == w_last_idx) begin
                            r_state  <= S_IDLE;
                            r_a_fill <= '0;
                            r_b_fill <= '0;
                        end else begin
                            r_state <= S_ISSUE;
                            r_i     <= w_i_nxt;
                            r_j     <= w_jlo_nxt;
                            r_acc   <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
